// File: rtl/drt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drt_pkg
// Shared constants and types for the device registration table.
// ----------------------------------------------------------------------------
package drt_pkg;

  // default geometry
  localparam int SLOTS_PER_PAGE_DEF = 32;
  localparam int PAGE_COUNT_DEF     = 32;

  // field widths
  localparam int PAGE_W     = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CAT_W      = 2;
  localparam int HEAD_W     = 8;
  localparam int GC_W       = 32;
  localparam int ID_W       = 24;
  localparam int STATUS_W   = 2;
  localparam int SLOT_IDX_W = 10;
  localparam int REC_W      = HEAD_W + GC_W + ID_W;

  // operations
  localparam logic OP_REGISTER = 1'b0;
  localparam logic OP_DELETE   = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CALL_FIRST   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOST_FIRST   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_FIRST  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CANCEL_FIRST = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_END    = 3'd4;

  // configuration reset values
  localparam logic [PAGE_W-1:0] CALL_FIRST_RST   = 6'd0;
  localparam logic [PAGE_W-1:0] HOST_FIRST_RST   = 6'd8;
  localparam logic [PAGE_W-1:0] ALARM_FIRST_RST  = 6'd16;
  localparam logic [PAGE_W-1:0] CANCEL_FIRST_RST = 6'd24;
  localparam logic [PAGE_W-1:0] TABLE_END_RST    = 6'd32;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STS_NEW     = 2'd0,
    STS_FOUND   = 2'd1,
    STS_FULL    = 2'd2,
    STS_DELETED = 2'd3
  } status_t;

endpackage

// File: rtl/device_registration_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// device_registration_table
// Slot table for paired transmitters: register with duplicate search, and
// delete by group code over a category range of pages.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per command (register or delete). Accepted when in_valid
//           is high and in_stall is low; in_stall is low only while idle.
//   out_* : one result beat per command, held in an output register until
//           taken. The next command is accepted while a result still waits.
//   cfg_* : page boundary writes, always ready; write only while idle.
// Scan: a command walks its slot window with one memory read per slot.
//   Register: window runs from the lower start to the higher end of the search
//   span and the category range, ending early on the first duplicate; delete:
//   the category range. The single read port sets the pace of the walk; a new
//   command is taken only after the last one has moved its result out.
// Reset: a clearing pass writes every slot free, with in_stall high.
//   Config regs reset.
// Out stall: a finished command waits until the output register is free.
// ----------------------------------------------------------------------------
module device_registration_table #(
  parameter int SLOTS_PER_PAGE = drt_pkg::SLOTS_PER_PAGE_DEF,
  parameter int PAGE_COUNT     = drt_pkg::PAGE_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_operation,
  input  logic [drt_pkg::CAT_W-1:0]        in_category,
  input  logic [drt_pkg::HEAD_W-1:0]       in_record_head,
  input  logic [drt_pkg::GC_W-1:0]         in_group_code,
  input  logic [drt_pkg::ID_W-1:0]         in_device_id,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [drt_pkg::STATUS_W-1:0]     out_status,
  output logic [drt_pkg::GC_W-1:0]         out_found_group_code,
  output logic [drt_pkg::SLOT_IDX_W-1:0]   out_slot_index,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [drt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [drt_pkg::PAGE_W-1:0]       cfg_data
);
  import drt_pkg::*;

  localparam int SLOT_TOTAL = SLOTS_PER_PAGE * PAGE_COUNT;
  localparam int SW = (SLOT_TOTAL > 1) ? $clog2(SLOT_TOTAL) : 1;
  localparam int BW = $clog2(SLOT_TOTAL + 1);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_FIN   = 4'b1000
  } state_t;

  // page boundaries
  logic [PAGE_W-1:0] call_first_r, host_first_r, alarm_first_r;
  logic [PAGE_W-1:0] cancel_first_r, table_end_r;

  state_t            state_r, state_nxt;
  logic [SW-1:0]     clr_r, clr_nxt;
  logic              op_r, op_nxt;
  logic [HEAD_W-1:0] head_r, head_nxt;
  logic [GC_W-1:0]   gc_r, gc_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [BW-1:0]     lo_r, lo_nxt, hi_r, hi_nxt;
  logic [BW-1:0]     slo_r, slo_nxt, shi_r, shi_nxt;
  logic [BW-1:0]     end_r, end_nxt;
  logic [BW-1:0]     rd_addr_r, rd_addr_nxt;
  logic              pend_r, pend_nxt;
  logic [SW-1:0]     pend_slot_r, pend_slot_nxt;
  logic              free_found_r, free_found_nxt;
  logic [SW-1:0]     free_slot_r, free_slot_nxt;
  status_t           res_status_r, res_status_nxt;
  logic [GC_W-1:0]   res_gc_r, res_gc_nxt;
  logic [SW-1:0]     res_slot_r, res_slot_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [GC_W-1:0]   out_gc_r, out_gc_nxt;
  logic [SW-1:0]     out_slot_r, out_slot_nxt;

  // slot memory: {used, head, group code, device id}
  logic [REC_W:0]    mem [SLOT_TOTAL];
  logic [REC_W:0]    rd_data_r;
  logic              rd_en;
  logic              mem_we;
  logic [SW-1:0]     mem_wa;
  logic [REC_W:0]    mem_wd;

  logic              rd_used;
  logic [GC_W-1:0]   rd_gc;
  logic [ID_W-1:0]   rd_id;
  logic              in_cat, in_span, scan_done;
  logic [BW-1:0]     a_lo, a_hi, a_slo, a_shi;
  logic [CFG_IDX_W-1:0] cat_ext;

  function automatic logic [PAGE_W-1:0] bnd(input logic [CFG_IDX_W-1:0] k);
    logic [PAGE_W-1:0] p;
    case (k)
      CFG_CALL_FIRST:   p = call_first_r;
      CFG_HOST_FIRST:   p = host_first_r;
      CFG_ALARM_FIRST:  p = alarm_first_r;
      CFG_CANCEL_FIRST: p = cancel_first_r;
      default:          p = table_end_r;
    endcase
    return p;
  endfunction

  // page to first slot, pages past the table clamp to the end
  function automatic logic [BW-1:0] p2s(input logic [PAGE_W-1:0] p);
    int pg;
    pg = (int'(p) > PAGE_COUNT) ? PAGE_COUNT : int'(p);
    return BW'(pg * SLOTS_PER_PAGE);
  endfunction

  function automatic logic [SLOT_IDX_W-1:0] slot_out(input logic [SW-1:0] s);
    logic [SW+SLOT_IDX_W-1:0] t;
    t = {{SLOT_IDX_W{1'b0}}, s};
    return t[SLOT_IDX_W-1:0];
  endfunction

  assign in_stall             = (state_r != ST_IDLE);
  assign cfg_ready            = 1'b1;
  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_found_group_code = out_gc_r;
  assign out_slot_index       = slot_out(out_slot_r);

  assign rd_used = rd_data_r[REC_W];
  assign rd_gc   = rd_data_r[GC_W+ID_W-1:ID_W];
  assign rd_id   = rd_data_r[ID_W-1:0];

  assign in_cat    = (BW'(pend_slot_r) >= lo_r) && (BW'(pend_slot_r) < hi_r);
  assign in_span   = (BW'(pend_slot_r) >= slo_r) && (BW'(pend_slot_r) < shi_r);
  assign scan_done = !pend_r && (rd_addr_r >= end_r);

  assign cat_ext = {1'b0, in_category};
  assign a_lo    = p2s(bnd(cat_ext));
  assign a_hi    = p2s(bnd(cat_ext + CFG_IDX_W'(1)));
  assign a_slo   = p2s(call_first_r);
  assign a_shi   = p2s(table_end_r);

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    op_nxt         = op_r;
    head_nxt       = head_r;
    gc_nxt         = gc_r;
    id_nxt         = id_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    slo_nxt        = slo_r;
    shi_nxt        = shi_r;
    end_nxt        = end_r;
    rd_addr_nxt    = rd_addr_r;
    pend_nxt       = pend_r;
    pend_slot_nxt  = pend_slot_r;
    free_found_nxt = free_found_r;
    free_slot_nxt  = free_slot_r;
    res_status_nxt = res_status_r;
    res_gc_nxt     = res_gc_r;
    res_slot_nxt   = res_slot_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_gc_nxt     = out_gc_r;
    out_slot_nxt   = out_slot_r;
    rd_en          = 1'b0;
    mem_we         = 1'b0;
    mem_wa         = '0;
    mem_wd         = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        mem_we  = 1'b1;
        mem_wa  = clr_r;
        clr_nxt = clr_r + SW'(1);
        if (clr_r == SW'(SLOT_TOTAL - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt         = in_operation;
          head_nxt       = in_record_head;
          gc_nxt         = in_group_code;
          id_nxt         = in_device_id;
          lo_nxt         = a_lo;
          hi_nxt         = a_hi;
          slo_nxt        = a_slo;
          shi_nxt        = a_shi;
          pend_nxt       = 1'b0;
          free_found_nxt = 1'b0;
          if (in_operation == OP_REGISTER) begin
            // walk from the lower start to the higher end of search span and category range
            rd_addr_nxt = (a_slo < a_lo) ? a_slo : a_lo;
            end_nxt     = (a_shi > a_hi) ? a_shi : a_hi;
          end else begin
            rd_addr_nxt = a_lo;
            end_nxt     = a_hi;
          end
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_addr_r < end_r) begin
          rd_en         = 1'b1;
          pend_nxt      = 1'b1;
          pend_slot_nxt = rd_addr_r[SW-1:0];
          rd_addr_nxt   = rd_addr_r + BW'(1);
        end else begin
          pend_nxt = 1'b0;
        end
        if (op_r == OP_REGISTER) begin
          if (pend_r && rd_used && in_span && (rd_id == id_r)) begin
            // ascending walk: first hit is the lowest slot
            res_status_nxt = STS_FOUND;
            res_gc_nxt     = rd_gc;
            res_slot_nxt   = pend_slot_r;
            state_nxt      = ST_FIN;
          end else begin
            if (pend_r && !rd_used && in_cat && !free_found_r) begin
              free_found_nxt = 1'b1;
              free_slot_nxt  = pend_slot_r;
            end
            if (scan_done) begin
              if (free_found_r) begin
                mem_we         = 1'b1;
                mem_wa         = free_slot_r;
                mem_wd         = {1'b1, head_r, gc_r, id_r};
                res_status_nxt = STS_NEW;
                res_slot_nxt   = free_slot_r;
              end else begin
                res_status_nxt = STS_FULL;
                res_slot_nxt   = '0;
              end
              res_gc_nxt = '0;
              state_nxt  = ST_FIN;
            end
          end
        end else begin
          // read of slot n+1 overlaps the write-back of slot n
          if (pend_r && in_cat && ((gc_r == '0) || (rd_used && (rd_gc == gc_r)))) begin
            mem_we = 1'b1;
            mem_wa = pend_slot_r;
            mem_wd = {1'b0, rd_data_r[REC_W-1:0]};
          end
          if (scan_done) begin
            res_status_nxt = STS_DELETED;
            res_gc_nxt     = '0;
            res_slot_nxt   = '0;
            state_nxt      = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_gc_nxt     = res_gc_r;
          out_slot_nxt   = res_slot_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr_r[SW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      call_first_r   <= CALL_FIRST_RST;
      host_first_r   <= HOST_FIRST_RST;
      alarm_first_r  <= ALARM_FIRST_RST;
      cancel_first_r <= CANCEL_FIRST_RST;
      table_end_r    <= TABLE_END_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CALL_FIRST:   call_first_r   <= cfg_data;
        CFG_HOST_FIRST:   host_first_r   <= cfg_data;
        CFG_ALARM_FIRST:  alarm_first_r  <= cfg_data;
        CFG_CANCEL_FIRST: cancel_first_r <= cfg_data;
        CFG_TABLE_END:    table_end_r    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_r        <= '0;
      pend_r       <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      pend_r       <= pend_nxt;
      free_found_r <= free_found_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    head_r       <= head_nxt;
    gc_r         <= gc_nxt;
    id_r         <= id_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    slo_r        <= slo_nxt;
    shi_r        <= shi_nxt;
    end_r        <= end_nxt;
    rd_addr_r    <= rd_addr_nxt;
    pend_slot_r  <= pend_slot_nxt;
    free_slot_r  <= free_slot_nxt;
    res_status_r <= res_status_nxt;
    res_gc_r     <= res_gc_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_gc_r     <= out_gc_nxt;
    out_slot_r   <= out_slot_nxt;
  end

  // no slot write while waiting for a command
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !mem_we)
    else $error("slot memory written while idle");

  // after a read the pointer never runs past the window end
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SCAN) && pend_r) |-> (rd_addr_r <= end_r))
    else $error("scan pointer past window end");

  // a delete only ever frees slots
  a_delete_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && (state_r == ST_SCAN) && (op_r == OP_DELETE)) |-> !mem_wd[REC_W])
    else $error("delete marked a slot used");

  // a new registration result is preceded by its slot write
  a_new_written: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SCAN) && (state_nxt == ST_FIN) && (op_r == OP_REGISTER) &&
     (res_status_nxt == STS_NEW)) |-> (mem_we && mem_wd[REC_W]))
    else $error("new registration without slot write");

endmodule
